// ===== rtl/rhfc_pkg.sv =====
// package for the reason hysteresis frequency cap unit
// holds sizes, reset defaults, item codes and the cell chain link type
// no dependencies
`timescale 1ns / 1ps

package rhfc_pkg;

  localparam int REASON_MAX = 16;
  localparam int NUM_REASONS_DEF = 16;
  localparam int BASE_REASON_DEF = 0;
  localparam logic [31:0] CAP_RESET_DEF = 32'd2147483647;

  localparam int FREQ_W = 32;
  localparam int HOLD_W = 32;
  localparam int TIME_W = 64;
  localparam int IDX_W = 4;

  localparam int S_DATA_W = 152;
  localparam int M_DATA_W = 56;

  localparam logic ACT_UPDATE = 1'b0;
  localparam logic ACT_LOAD = 1'b1;

  typedef struct packed {
    logic go;
    logic [FREQ_W-1:0] cap;
  } rhfc_link_t;

endpackage

// ===== rtl/rhfc_cell.sv =====
// one reason cell: active bit, release time, frequency and hold time
// takes the running cap from its left neighbor and hands it on; uses rhfc_pkg
`timescale 1ns / 1ps

module rhfc_cell
  import rhfc_pkg::*;
#(
  parameter logic [FREQ_W-1:0] CAP_RESET = CAP_RESET_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  rhfc_link_t        link_in,
  output rhfc_link_t        link_out,
  input  logic [TIME_W-1:0] now_time,
  input  logic              present,
  input  logic              load_en,
  input  logic [FREQ_W-1:0] load_freq,
  input  logic [HOLD_W-1:0] load_hold,
  output logic              active,
  output logic [FREQ_W-1:0] freq
);

  logic [TIME_W-1:0] rel;
  logic [HOLD_W-1:0] hold;
  logic [TIME_W-1:0] rel_mid;
  logic [TIME_W-1:0] elapsed;
  logic              expire;
  logic              counts;
  logic [FREQ_W-1:0] cap_next;

  always_comb begin
    if (present) begin
      rel_mid = '0;
    end else if (active && rel == '0) begin
      rel_mid = now_time;
    end else begin
      rel_mid = rel;
    end
    elapsed  = now_time - rel_mid;
    expire   = active && (rel_mid != '0) &&
               (elapsed >= {{(TIME_W-HOLD_W){1'b0}}, hold});
    counts   = active && !expire;
    cap_next = (counts && freq > link_in.cap) ? freq : link_in.cap;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      rel <= '0;
      freq <= CAP_RESET;
      hold <= '0;
      link_out.go <= 1'b0;
    end else begin
      link_out.go <= link_in.go;
      link_out.cap <= cap_next;
      if (link_in.go) begin
        active <= present | counts;
        rel <= expire ? '0 : rel_mid;
      end
      if (load_en) begin
        freq <= load_freq;
        hold <= load_hold;
      end
    end
  end

endmodule

// ===== rtl/reason_hysteresis_freq_cap_unit.sv =====
// top level of the reason hysteresis frequency cap unit
// a row of rhfc_cell instances, one per reason, plus control and output word
// depends on rhfc_pkg and rhfc_cell
`timescale 1ns / 1ps

// An update word walks the row of reason cells, one cell per cycle, carrying
// the running cap. Its result passes the head register, each cell's register,
// the register that takes the new cap and then the output register, after which
// the next word is accepted. A load word skips the row and its result goes
// straight to the output register. One word is in work at a time; the next word
// is taken while the previous result still waits in the output register, and a
// finished result waits until that register is free.
module reason_hysteresis_freq_cap_unit
  import rhfc_pkg::*;
#(
  parameter int NUM_REASONS = NUM_REASONS_DEF,
  parameter int BASE_REASON = BASE_REASON_DEF,
  parameter logic [FREQ_W-1:0] CAP_RESET = CAP_RESET_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  // reasons_now[15:0], now_time[79:16], entry_index[83:80],
  // entry_freq[115:84], entry_hold[147:116], zero fill
  input  logic [S_DATA_W-1:0] s_tdata,
  // action[0]
  input  logic                s_tuser,
  output logic                m_tvalid,
  input  logic                m_tready,
  // cap_khz[31:0], cap_changed[32], active_reasons[48:33], zero fill
  output logic [M_DATA_W-1:0] m_tdata
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  logic [REASON_MAX-1:0] present;
  logic [TIME_W-1:0]     now_time;
  logic [FREQ_W-1:0]     current_cap;
  logic [FREQ_W-1:0]     res_cap;
  logic                  res_changed;

  rhfc_link_t            link_head;
  rhfc_link_t            link [NUM_REASONS+1];
  logic [FREQ_W-1:0]     cell_freq [NUM_REASONS];
  logic [REASON_MAX-1:0] active_vec;
  logic [NUM_REASONS:0]  go_vec;
  logic [FREQ_W-1:0]     base_freq;

  logic [REASON_MAX-1:0] in_reasons;
  logic [TIME_W-1:0]     in_time;
  logic [IDX_W-1:0]      in_index;
  logic [FREQ_W-1:0]     in_freq;
  logic [HOLD_W-1:0]     in_hold;
  logic                  s_fire;
  logic                  out_free;

  assign in_reasons = s_tdata[15:0];
  assign in_time    = s_tdata[79:16];
  assign in_index   = s_tdata[83:80];
  assign in_freq    = s_tdata[115:84];
  assign in_hold    = s_tdata[147:116];

  assign s_tready = (state == ST_IDLE);
  assign s_fire   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  assign link[0] = link_head;

  generate
    if (BASE_REASON < NUM_REASONS) begin : g_base_in
      assign base_freq = cell_freq[BASE_REASON];
    end else begin : g_base_out
      assign base_freq = CAP_RESET;
    end
  endgenerate

  genvar k;
  generate
    for (k = 0; k < NUM_REASONS; k++) begin : g_cell
      rhfc_cell #(
        .CAP_RESET(CAP_RESET)
      ) u_cell (
        .clk      (clk),
        .rst      (rst),
        .link_in  (link[k]),
        .link_out (link[k+1]),
        .now_time (now_time),
        .present  (present[k]),
        .load_en  (s_fire && s_tuser == ACT_LOAD && in_index == IDX_W'(k)),
        .load_freq(in_freq),
        .load_hold(in_hold),
        .active   (active_vec[k]),
        .freq     (cell_freq[k])
      );
    end
    for (k = NUM_REASONS; k < REASON_MAX; k++) begin : g_pad
      assign active_vec[k] = 1'b0;
    end
    for (k = 0; k <= NUM_REASONS; k++) begin : g_go
      assign go_vec[k] = link[k].go;
    end
  endgenerate

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (s_fire) begin
          state_next = (s_tuser == ACT_LOAD) ? ST_DONE : ST_RUN;
        end
      end
      ST_RUN: begin
        if (link[NUM_REASONS].go) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      current_cap <= CAP_RESET;
      m_tvalid <= 1'b0;
      link_head.go <= 1'b0;
      res_changed <= 1'b0;
    end else begin
      state <= state_next;
      link_head.go <= s_fire && s_tuser == ACT_UPDATE;
      link_head.cap <= base_freq;
      if (s_fire) begin
        res_changed <= 1'b0;
      end
      if (state == ST_RUN && link[NUM_REASONS].go) begin
        res_changed <= (link[NUM_REASONS].cap != current_cap);
        current_cap <= link[NUM_REASONS].cap;
      end
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (state == ST_DONE && out_free) begin
        m_tvalid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_fire) begin
      present <= in_reasons;
      now_time <= in_time;
      res_cap <= current_cap;
    end
    if (state == ST_RUN && link[NUM_REASONS].go) begin
      res_cap <= link[NUM_REASONS].cap;
    end
    if (state == ST_DONE && out_free) begin
      m_tdata <= {7'd0, active_vec, res_changed, res_cap};
    end
  end

  a_one_token : assert property (@(posedge clk) disable iff (rst)
    $onehot0(go_vec))
    else $error("more than one update in the cell row");

  a_idle_empty : assert property (@(posedge clk) disable iff (rst)
    state == ST_IDLE |-> go_vec == '0)
    else $error("cell row busy while idle");

  a_token_run : assert property (@(posedge clk) disable iff (rst)
    link[NUM_REASONS].go |-> state == ST_RUN)
    else $error("update left the row outside run state");

  a_out_hold : assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("output word changed while waiting");

endmodule
